[design/cse_pkg.sv]
// Shared constants, types and datapath command codes for the cubic spline evaluator.
// Used by cse_ctrl, cse_dp and cubic_spline_evaluator; no dependencies.
package cse_pkg;

  localparam int MAX_KNOTS = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_KNOTS);
  localparam int CNT_W     = 7;
  localparam int ENTRY_W   = 160;
  localparam int IN_W      = 200;
  localparam int OUT_W     = 40;
  localparam int DIV_STEPS = 33;

  localparam logic [1:0] MODE_PERIODIC = 2'd0;
  localparam logic [1:0] MODE_NATURAL  = 2'd1;
  localparam logic [1:0] MODE_CUBIC    = 2'd2;
  localparam logic       CMD_LOAD      = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_X0,
    OP_PERIOD,
    OP_DIVSTEP,
    OP_WRAPFIX,
    OP_CACHE,
    OP_SINIT,
    OP_SCMP,
    OP_SDONE,
    OP_ELOAD,
    OP_MUL,
    OP_ADD,
    OP_OUT
  } dp_op_e;

  typedef enum logic [2:0] {
    AS_ZERO,
    AS_LAST,
    AS_CACHE,
    AS_I,
    AS_I1,
    AS_K
  } addr_sel_e;

  typedef struct packed {
    dp_op_e    op;
    addr_sel_e addr;
  } cmd_t;

  typedef struct packed {
    logic do_wrap;
    logic cache_bad;
    logic ul_lt_x;
    logic x_lt_ul;
    logic i_top;
    logic srch_more;
    logic step_last;
    logic out_free;
  } sts_t;

endpackage

[design/cse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/cse_ctrl.sv]
// Sequencer for load and query items of the cubic spline evaluator.
// Depends on cse_pkg; drives cse_dp through cmd_t and reads sts_t.
module cse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_command_i,
  output logic          in_ready_o,
  input  cse_pkg::sts_t sts_i,
  output cse_pkg::cmd_t cmd_o
);
  import cse_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RX0   = 4'd1;
  localparam logic [3:0] S_RXL   = 4'd2;
  localparam logic [3:0] S_PER   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_FIX   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_CI    = 4'd7;
  localparam logic [3:0] S_CI1   = 4'd8;
  localparam logic [3:0] S_SINIT = 4'd9;
  localparam logic [3:0] S_SK    = 4'd10;
  localparam logic [3:0] S_SC    = 4'd11;
  localparam logic [3:0] S_ERD   = 4'd12;
  localparam logic [3:0] S_ELD   = 4'd13;
  localparam logic [3:0] S_MUL   = 4'd14;
  localparam logic [3:0] S_ADD   = 4'd15;

  localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS - 1);

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       out_wait_q, out_wait_d;

  assign in_ready_o = (state_q == S_IDLE) && !out_wait_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    out_wait_d = out_wait_q;
    cmd_o.op   = OP_NONE;
    cmd_o.addr = AS_ZERO;
    case (state_q)
      S_IDLE: begin
        if (out_wait_q) begin
          // hold the finished result until the output register frees up
          if (sts_i.out_free) begin
            cmd_o.op   = OP_OUT;
            out_wait_d = 1'b0;
          end
        end else if (in_valid_i) begin
          if (in_command_i == CMD_LOAD) begin
            cmd_o.op = OP_LOAD;
          end else begin
            cmd_o.op = OP_START;
            state_d  = S_RX0;
          end
        end
      end
      S_RX0: begin
        cmd_o.addr = AS_ZERO;
        state_d    = S_RXL;
      end
      S_RXL: begin
        cmd_o.op   = OP_X0;
        cmd_o.addr = AS_LAST;
        state_d    = S_PER;
      end
      S_PER: begin
        cmd_o.op = OP_PERIOD;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.do_wrap) begin
          state_d = S_CHK;
        end else begin
          cmd_o.op = OP_DIVSTEP;
          cnt_d    = cnt_q + 6'd1;
          if (cnt_q == DIV_LAST) begin
            state_d = S_FIX;
          end
        end
      end
      S_FIX: begin
        cmd_o.op = OP_WRAPFIX;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op   = OP_CACHE;
        cmd_o.addr = AS_CACHE;
        state_d    = sts_i.cache_bad ? S_SINIT : S_CI;
      end
      S_CI: begin
        cmd_o.addr = AS_I1;
        if (sts_i.ul_lt_x) begin
          state_d = S_SINIT;
        end else if (sts_i.i_top) begin
          state_d = S_ERD;
        end else begin
          state_d = S_CI1;
        end
      end
      S_CI1: begin
        state_d = sts_i.x_lt_ul ? S_SINIT : S_ERD;
      end
      S_SINIT: begin
        cmd_o.op = OP_SINIT;
        state_d  = S_SK;
      end
      S_SK: begin
        cmd_o.addr = AS_K;
        if (sts_i.srch_more) begin
          state_d = S_SC;
        end else begin
          cmd_o.op = OP_SDONE;
          state_d  = S_ERD;
        end
      end
      S_SC: begin
        cmd_o.op = OP_SCMP;
        state_d  = S_SK;
      end
      S_ERD: begin
        cmd_o.addr = AS_I;
        state_d    = S_ELD;
      end
      S_ELD: begin
        cmd_o.op = OP_ELOAD;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_ADD;
      end
      S_ADD: begin
        cmd_o.op = OP_ADD;
        if (sts_i.step_last) begin
          out_wait_d = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_MUL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      out_wait_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      out_wait_q <= out_wait_d;
    end
  end

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= DIV_LAST))
    else $error("remainder step count overran");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_command_i != CMD_LOAD) |=> !in_ready_o)
    else $error("ready stayed high after a query was accepted");

  a_out_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_wait_q && sts_i.out_free) |=> (!out_wait_q && state_q == S_IDLE))
    else $error("pending result not released");

endmodule

[design/cse_dp.sv]
// Datapath: knot RAM, periodic remainder, interval search and Horner evaluation.
// Depends on cse_pkg and cse_ram; commanded by cse_ctrl.
module cse_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cse_pkg::cmd_t               cmd_i,
  output cse_pkg::sts_t               sts_o,
  input  logic [1:0]                  mode_i,
  input  logic [cse_pkg::CNT_W-1:0]   knot_count_i,
  input  logic [cse_pkg::IN_W-1:0]    in_data_i,
  input  logic                        in_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [cse_pkg::OUT_W-1:0]   out_data_o,
  output logic                        out_last_o
);
  import cse_pkg::*;

  localparam logic [65:0] HALF = 66'(1) << (FRAC_BITS - 1);

  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] n_m1;
  always_comb begin
    n = knot_count_i;
    if (n < CNT_W'(2)) n = CNT_W'(2);
    if (n > CNT_W'(MAX_KNOTS)) n = CNT_W'(MAX_KNOTS);
    n_m1 = IDX_W'(n - CNT_W'(1));
  end

  logic signed [31:0] u_q, x0_q, ul_q, acc_q, y_q, b_q, c_q;
  logic               batch_q;
  logic        [32:0] period_q, a_q;
  logic               neg_q;
  logic        [33:0] rem_q;
  logic [IDX_W-1:0]   i_q, last_q;
  logic [CNT_W-1:0]   lo_q, hi_q;
  logic signed [32:0] t_q;
  logic signed [64:0] prod_q;
  logic [1:0]         step_q;
  logic               valid_q;
  logic signed [31:0] val_q;
  logic [IDX_W-1:0]   int_q;
  logic               olast_q;

  // knot RAM
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [7:0]         ksum;
  logic [IDX_W-1:0]   k;
  assign ksum = {1'b0, lo_q} + {1'b0, hi_q};
  assign k    = ksum[IDX_W:1];

  always_comb begin
    case (cmd_i.addr)
      AS_ZERO:  raddr = '0;
      AS_LAST:  raddr = n_m1;
      AS_CACHE: raddr = last_q;
      AS_I:     raddr = i_q;
      AS_I1:    raddr = i_q + IDX_W'(1);
      AS_K:     raddr = k;
      default:  raddr = '0;
    endcase
  end

  cse_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_KNOTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_LOAD),
    .waddr_i (in_data_i[IDX_W-1:0]),
    .wdata_i (in_data_i[IDX_W+ENTRY_W-1:IDX_W]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic signed [31:0] rx, ry, rb, rc, rd;
  assign rx = rdata[31:0];
  assign ry = rdata[63:32];
  assign rb = rdata[95:64];
  assign rc = rdata[127:96];
  assign rd = rdata[159:128];

  logic signed [32:0] diff, per_d;
  assign diff  = {u_q[31], u_q} - {x0_q[31], x0_q};
  assign per_d = {rx[31], rx} - {x0_q[31], x0_q};

  logic [33:0] rem_sh;
  logic [32:0] r_fix;
  assign rem_sh = {rem_q[32:0], a_q[32]};
  assign r_fix  = (neg_q && rem_q != '0) ? period_q - rem_q[32:0] : rem_q[32:0];

  // Horner step: round product, add coefficient, saturate
  logic signed [31:0] coef;
  logic signed [65:0] p, mag, rs, rnd, sum;
  logic signed [31:0] sat;
  always_comb begin
    case (step_q)
      2'd0:    coef = c_q;
      2'd1:    coef = b_q;
      default: coef = y_q;
    endcase
    p   = {prod_q[64], prod_q};
    mag = p[65] ? -p : p;
    rs  = (mag + HALF) >>> FRAC_BITS;
    rnd = p[65] ? -rs : rs;
    sum = {{34{coef[31]}}, coef} + rnd;
    if (!sum[65] && (|sum[64:31])) sat = 32'sh7fffffff;
    else if (sum[65] && !(&sum[64:31])) sat = 32'sh80000000;
    else sat = sum[31:0];
  end

  always_comb begin
    sts_o.do_wrap   = (mode_i == MODE_PERIODIC) && !period_q[32] && (period_q != '0);
    sts_o.cache_bad = {1'b0, last_q} >= n;
    sts_o.ul_lt_x   = ul_q < rx;
    sts_o.x_lt_ul   = rx < ul_q;
    sts_o.i_top     = i_q == n_m1;
    sts_o.srch_more = hi_q > (lo_q + CNT_W'(1));
    sts_o.step_last = step_q == 2'd2;
    sts_o.out_free  = !valid_q || out_ready_i;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        u_q     <= in_data_i[197:166];
        batch_q <= in_last_i;
      end
      OP_X0: x0_q <= rx;
      OP_PERIOD: begin
        period_q <= per_d;
        neg_q    <= diff[32];
        a_q      <= diff[32] ? 33'(-diff) : diff;
        rem_q    <= '0;
        ul_q     <= u_q;
      end
      OP_DIVSTEP: begin
        a_q   <= {a_q[31:0], 1'b0};
        rem_q <= (rem_sh >= {1'b0, period_q}) ? rem_sh - {1'b0, period_q} : rem_sh;
      end
      OP_WRAPFIX: ul_q <= 32'(x0_q + r_fix[31:0]);
      OP_CACHE:   i_q  <= last_q;
      OP_SINIT: begin
        lo_q <= '0;
        hi_q <= n;
      end
      OP_SCMP: begin
        if (ul_q < rx) hi_q <= {1'b0, k};
        else lo_q <= {1'b0, k};
      end
      OP_SDONE: i_q <= lo_q[IDX_W-1:0];
      OP_ELOAD: begin
        t_q   <= {ul_q[31], ul_q} - {rx[31], rx};
        acc_q <= (mode_i == MODE_NATURAL && ul_q < x0_q) ? 32'sd0 : rd;
        y_q   <= ry;
        b_q   <= rb;
        c_q   <= rc;
      end
      OP_MUL: prod_q <= t_q * acc_q;
      OP_ADD: acc_q  <= sat;
      OP_OUT: begin
        val_q   <= acc_q;
        int_q   <= i_q;
        olast_q <= batch_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_ELOAD) step_q <= '0;
      else if (cmd_i.op == OP_ADD) step_q <= step_q + 2'd1;
      if (cmd_i.op == OP_OUT) begin
        valid_q <= 1'b1;
        last_q  <= batch_q ? '0 : i_q;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {2'b00, int_q, val_q};
  assign out_last_o  = olast_q;

endmodule

[design/cubic_spline_evaluator.sv]
// Top level of the cubic spline evaluator: stream ports, APB registers, ctrl + datapath.
// Depends on cse_pkg, cse_ctrl, cse_dp (and cse_ram through cse_dp).
//
// Channel   | Dir | Handshake              | Contents
// s_axis    | in  | tvalid/tready          | load knot or query point
// m_axis    | out | tvalid/tready          | spline value and interval
// apb       | in  | psel/penable, pready=1 | mode (0x0), knot_count (0x4)
//
// A load writes the knot RAM on acceptance. A query runs through fixed work (accept,
// x0 and period reads, cache read, entry read, output release, a multiply and an add per
// Horner step), one or two cache compares (none when the cached interval is out of
// range), the periodic remainder (one quotient bit per cycle, then the wrap), and on a
// cache miss a binary search of up to six probes at 64 knots.
// The single read port of the knot RAM and the bit-serial remainder set the query time.
// Reset clears the interval cache, the APB registers and the output valid; knot
// contents stay undefined until loaded. A stalled result waits in the output register;
// a finished result waits behind it, and no new item is accepted until it has moved in.
module cubic_spline_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: knot_index[5:0], knot_x, knot_y, coef_b, coef_c, coef_d,
  // query_u (32 each), 2 zero bits
  input  logic [cse_pkg::IN_W-1:0] s_axis_tdata,
  // tuser: command (0 load, 1 query)
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: value[31:0], interval[5:0], 2 zero bits
  output logic [cse_pkg::OUT_W-1:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cse_pkg::*;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  logic [1:0]       mode_q;
  logic [CNT_W-1:0] count_q;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // register write; decode on word address only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_CUBIC;
      count_q <= CNT_W'(2);
    end else if (wr) begin
      case (paddr[2])
        REG_MODE:  mode_q  <= pwdata[1:0];
        REG_COUNT: count_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = {30'd0, mode_q};
      REG_COUNT: prdata = {25'd0, count_q};
      default:   prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;

  cse_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_command_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  cse_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_q),
    .knot_count_i (count_q),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

[verif/tb_cubic_spline_evaluator.sv]
// Self-checking testbench for cubic_spline_evaluator: knot loads, queries in every mode.
// Depends on cse_pkg and the RTL top level; a built-in predictor checks each result.
`timescale 1ns / 1ps
module tb_cubic_spline_evaluator;
  import cse_pkg::*;

  localparam int LATENCY_WAIT = 120;
  localparam int WATCHDOG_MAX = 6000;
  localparam int LONG_HOLD    = 300;
  localparam logic CMD_QUERY  = 1'b1;
  localparam logic [2:0] ADDR_MODE  = 3'd0;
  localparam logic [2:0] ADDR_COUNT = 3'd4;

  typedef struct {
    logic        cmd;
    logic [5:0]  idx;
    logic signed [31:0] x, y, b, c, d, u;
    logic        last;
  } knot_item_t;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  interval;
    logic        last;
  } spline_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cubic_spline_evaluator dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: knot table, registers and the interval cache.
  int kx[MAX_KNOTS], ky[MAX_KNOTS], kb[MAX_KNOTS], kc[MAX_KNOTS], kd[MAX_KNOTS];
  logic [1:0] mode_q = 2'd2;
  logic [6:0] count_q = 7'd2;
  int unsigned cached_iv = 0;

  knot_item_t  pending_items[$];
  spline_res_t expected_vals[$];
  int err_cnt = 0;
  int n_loads = 0, n_queries = 0, n_results = 0;
  int sender_idle_pct = 0, recv_stall_pct = 0;
  int hold_req = 0;
  int grid[MAX_KNOTS];   // x values the stimulus currently believes are loaded

  // One Horner step: round the Q32 product back to Q16, add, saturate.
  function automatic longint horner_step(longint t, longint acc, int coef);
    longint p, r;
    p = t * acc;
    if (p >= 0) r = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    else r = -((-p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    r = r + longint'(coef);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic void predict_spline(knot_item_t it);
    int unsigned n, iv, lo, hi, k;
    longint ul, x0, period, r, t, acc;
    logic need_search;
    spline_res_t res;
    if (it.cmd == CMD_LOAD) begin
      kx[it.idx] = it.x; ky[it.idx] = it.y;
      kb[it.idx] = it.b; kc[it.idx] = it.c; kd[it.idx] = it.d;
      n_loads++;
      return;
    end
    n_queries++;
    n = count_q;
    if (n < 2) n = 2;
    if (n > MAX_KNOTS) n = MAX_KNOTS;
    ul = longint'(it.u);
    x0 = longint'(kx[0]);
    if (mode_q == MODE_PERIODIC) begin
      period = longint'(kx[n-1]) - x0;
      if (period > 0) begin
        r = (ul - x0) % period;
        if (r < 0) r = r + period;
        ul = r + x0;
      end
    end
    iv = cached_iv;
    if (iv >= n) need_search = 1'b1;
    else if (ul < longint'(kx[iv])) need_search = 1'b1;
    else if (iv != n - 1 && longint'(kx[iv+1]) < ul) need_search = 1'b1;
    else need_search = 1'b0;
    if (need_search) begin
      lo = 0;
      hi = n;
      while (hi > lo + 1) begin
        k = (lo + hi) / 2;
        if (ul < longint'(kx[k])) hi = k;
        else lo = k;
      end
      iv = lo;
    end
    t = ul - longint'(kx[iv]);
    acc = longint'(kd[iv]);
    // natural mode: the cubic coefficient is dropped left of the first knot
    if (mode_q == MODE_NATURAL && ul < x0) acc = 0;
    acc = horner_step(t, acc, kc[iv]);
    acc = horner_step(t, acc, kb[iv]);
    acc = horner_step(t, acc, ky[iv]);
    res.value = acc[31:0];
    res.interval = iv[5:0];
    res.last = it.last;
    expected_vals.push_back(res);
    cached_iv = it.last ? 0 : iv;
  endfunction

  // Driver: present items from the pending queue, idle at random between them.
  always @(posedge clk_i) begin
    knot_item_t nxt;
    logic present;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        nxt.cmd = s_axis_tuser;
        nxt.idx = s_axis_tdata[5:0];
        nxt.x = s_axis_tdata[37:6];
        nxt.y = s_axis_tdata[69:38];
        nxt.b = s_axis_tdata[101:70];
        nxt.c = s_axis_tdata[133:102];
        nxt.d = s_axis_tdata[165:134];
        nxt.u = s_axis_tdata[197:166];
        nxt.last = s_axis_tlast;
        predict_spline(nxt);
      end
      // hold the current item until it is taken
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        present = pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct;
        if (present) begin
          nxt = pending_items.pop_front();
          s_axis_tdata <= {2'b00, nxt.u, nxt.d, nxt.c, nxt.b, nxt.y, nxt.x, nxt.idx};
          s_axis_tuser <= nxt.cmd;
          s_axis_tlast <= nxt.last;
        end
        s_axis_tvalid <= present;
      end
    end
  end

  // Monitor: stall at random or for a long requested stretch, check each result.
  int hold_seen = 0, hold_left = 0;
  always @(posedge clk_i) begin
    spline_res_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_vals.size() == 0) begin
          $error("result with no expectation: value %h", m_axis_tdata[31:0]);
          err_cnt++;
        end else begin
          exp_r = expected_vals.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.value) begin
            $error("value: expected %h, got %h", exp_r.value, m_axis_tdata[31:0]);
            err_cnt++;
          end
          if (m_axis_tdata[37:32] !== exp_r.interval) begin
            $error("interval: expected %0d, got %0d", exp_r.interval, m_axis_tdata[37:32]);
            err_cnt++;
          end
          if (m_axis_tlast !== exp_r.last) begin
            $error("last_of_batch: expected %b, got %b", exp_r.last, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on either stream or the APB bus.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_MAX);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    // the register takes the value at this edge
    if (addr == ADDR_MODE) mode_q = data[1:0];
    else count_q = data[6:0];
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_vals.size() != 0)
      @(posedge clk_i);
    // a trailing load may still be in flight
    repeat (LATENCY_WAIT) @(posedge clk_i);
  endtask

  task automatic configure(logic [1:0] md, logic [6:0] cnt);
    wait_drained();
    apb_write(ADDR_MODE, {30'd0, md});
    apb_write(ADDR_COUNT, {25'd0, cnt});
    @(negedge clk_i);
  endtask

  function automatic int coef_rand();
    if ($urandom_range(0, 4) == 0) return int'($urandom);
    return int'($urandom_range(0, 32'h0007_ffff)) - 32'h0004_0000;
  endfunction

  function automatic void push_load(int unsigned idx, int xv);
    knot_item_t it;
    it.cmd = CMD_LOAD; it.idx = idx[5:0]; it.x = xv; it.u = int'($urandom);
    it.y = int'($urandom); it.b = coef_rand(); it.c = coef_rand(); it.d = coef_rand();
    it.last = $urandom_range(0, 1);
    grid[idx] = xv;
    pending_items.push_back(it);
  endfunction

  function automatic void push_query(int uv, logic last);
    knot_item_t it;
    it.cmd = CMD_QUERY; it.idx = $urandom; it.u = uv; it.last = last;
    it.x = int'($urandom); it.y = int'($urandom); it.b = int'($urandom);
    it.c = int'($urandom); it.d = int'($urandom);
    pending_items.push_back(it);
  endfunction

  // Pick a point: near a knot in use, near the previous point, or anywhere.
  int prev_u = 0;
  function automatic int pick_point(int unsigned n);
    int unsigned sel, k;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      k = $urandom_range(0, n - 1);
      pick_point = grid[k] + int'($urandom_range(0, 32'h0200_0000)) - 32'h0000_1000;
    end else if (sel < 8) begin
      pick_point = prev_u + int'($urandom_range(0, 32'h0004_0000));
    end else begin
      pick_point = int'($urandom);
    end
    prev_u = pick_point;
  endfunction

  int unsigned cnt_list[8] = '{64, 2, 5, 64, 33, 127, 0, 17};
  int idle_list[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{31, 31}};

  initial begin
    int unsigned n_use;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fill the whole table with ascending knots spread over the full x range.
    for (int k = 0; k < MAX_KNOTS; k++)
      push_load(k, int'(32'h8000_0000 + k * 32'h0400_0000 + $urandom_range(0, 32'h01ff_ffff)));
    configure(2'd2, 7'd64);

    // Directed: range extremes, first and last knot, per mode.
    for (int md = 0; md < 3; md++) begin
      configure(md[1:0], 7'd8);
      push_query(32'sh7fff_ffff, 1'b0);
      push_query(32'sh8000_0000, 1'b0);
      push_query(grid[0] - 1, 1'b0);     // left of the first knot
      push_query(grid[0], 1'b0);
      push_query(grid[7], 1'b0);         // last interval, open above
      push_query(grid[7] + 32'h0100_0000, 1'b1);
    end
    // Shrink the count under a cached top interval to force a fresh search.
    configure(2'd2, 7'd64);
    push_query(grid[63] + 5, 1'b0);
    configure(2'd3, 7'd1);
    push_query(grid[1] + 7, 1'b1);

    // Random phases across modes, counts and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      configure(ph[1:0], cnt_list[ph][6:0]);
      sender_idle_pct = idle_list[ph % 4][0];
      recv_stall_pct = idle_list[ph % 4][1];
      n_use = cnt_list[ph];
      if (n_use < 2) n_use = 2;
      if (n_use > MAX_KNOTS) n_use = MAX_KNOTS;
      if (ph == 1) hold_req++;           // long receiver hold while items keep coming
      for (int j = 0; j < 70; j++) begin
        if ($urandom_range(0, 3) == 0) begin
          int unsigned k;
          k = $urandom_range(0, MAX_KNOTS - 1);
          // occasionally scramble an abscissa; otherwise keep the grid
          push_load(k, ($urandom_range(0, 11) == 0) ? int'($urandom) : grid[k]);
        end else begin
          push_query(pick_point(n_use), $urandom_range(0, 4) == 0);
        end
        if (ph == 4 && j == 35) begin
          // pause the sender until every pending result is back
          while (pending_items.size() != 0 || s_axis_tvalid || expected_vals.size() != 0)
            @(negedge clk_i);
        end
      end
    end

    sender_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    $display("Covered %0d knot loads and %0d queries, %0d results checked,", n_loads,
             n_queries, n_results);
    $display("over all four mode codes, clamped knot counts and four idling patterns.");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[cubic_spline_evaluator.f]
design/cse_pkg.sv
design/cse_ram.sv
design/cse_ctrl.sv
design/cse_dp.sv
design/cubic_spline_evaluator.sv
verif/tb_cubic_spline_evaluator.sv
